// ----- src/pidaw_pkg.sv -----
// Package for the PID controller with integral anti-windup and filtered derivative.
// Holds the register map shared by the register file and the datapath.
// No dependencies.
package pidaw_pkg;

   // Number of configuration registers
   localparam int NUM_REGS = 8;

   // Register map, in address order
   typedef enum logic [2:0] {
      REG_PROP_GAIN   = 3'd0,
      REG_INTEG_COEF  = 3'd1,
      REG_DERIV_NUM   = 3'd2,
      REG_DERIV_DEN   = 3'd3,
      REG_INTEG_UPPER = 3'd4,
      REG_INTEG_LOWER = 3'd5,
      REG_OUT_UPPER   = 3'd6,
      REG_OUT_LOWER   = 3'd7
   } csr_index_type;

endpackage

// ----- src/pidaw_if.sv -----
// Valid/ready channel interfaces for the PID controller: sample in, result out.
// Widths follow the DW parameter. Depends on nothing.
interface pidaw_req_if #(parameter int DW = 32);
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] setpoint;
   logic signed [DW-1:0] measured;

   modport source (output valid, output setpoint, output measured, input ready);
   modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface pidaw_rsp_if #(parameter int DW = 32);
   logic                 valid;
   logic                 ready;
   logic signed [DW-1:0] drive;
   logic                 integ_frozen;

   modport source (output valid, output drive, output integ_frozen, input ready);
   modport sink   (input valid, input drive, input integ_frozen, output ready);
endinterface

// ----- src/pid_antiwindup_filtered_d.sv -----
// Top level of the discrete PID controller with integral anti-windup.
// Depends on pidaw_pkg, pidaw_if, pidaw_regs and pidaw_core.
//
// Usage:
//   req_ch carries one sample beat (setpoint, measured, signed fixed point).
//   rsp_ch carries one result beat per sample (drive, integ_frozen).
//   The csr_ port is an APB-style slave; registers lie at 4*index (8*index
//   when DATA_WIDTH exceeds 32). pready is tied high. Write the gains and
//   limits only while no sample is in flight.
// Timing:
//   A sample lands in the input register, is processed by the combinational
//   datapath, whose loop state (last error, integral, derivative, freeze)
//   updates at the edge that loads the result into the result register.
//   One sample per cycle is sustained while rsp_ch takes every result.
// Reset (synchronous, active high) clears loop state, empties both pipeline
//   registers and returns the registers to zero gains and wide-open limits.
// Stall: while rsp_ch is not taken the result holds; one more sample is
//   still taken into the input register, then req_ch.ready drops.
module pid_antiwindup_filtered_d #(
   parameter int  DATA_WIDTH = 32,
   parameter int  FRAC_BITS  = 16,
   localparam int CSR_DW     = (DATA_WIDTH > 32) ? 64 : 32,
   localparam int CSR_AW     = $clog2(pidaw_pkg::NUM_REGS * CSR_DW / 8)
) (
   input  logic              clock,
   input  logic              reset,
   pidaw_req_if.sink         req_ch,
   pidaw_rsp_if.source       rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic signed [DATA_WIDTH-1:0] coef [pidaw_pkg::NUM_REGS];

   logic                         in_vld_ff;
   logic signed [DATA_WIDTH-1:0] in_sp_ff, in_ms_ff;
   logic                         rsp_vld_ff;
   logic signed [DATA_WIDTH-1:0] rsp_drive_ff, rsp_drive_in;
   logic                         rsp_frz_ff, rsp_frz_in;
   logic                         move;
   logic                         take;

   assign csr_pready = 1'b1;

   pidaw_regs #(
      .DW     (DATA_WIDTH),
      .CSR_DW (CSR_DW),
      .CSR_AW (CSR_AW)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .coef    (coef)
   );

   // Process the held sample when the result register is free
   assign move          = in_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign take          = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = !in_vld_ff || move;

   pidaw_core #(
      .DW   (DATA_WIDTH),
      .FRAC (FRAC_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (move),
      .setpoint (in_sp_ff),
      .measured (in_ms_ff),
      .coef     (coef),
      .drive    (rsp_drive_in),
      .frozen   (rsp_frz_in)
   );

   // Input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (take) begin
         in_vld_ff <= 1'b1;
      end else if (move) begin
         in_vld_ff <= 1'b0;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (take) begin
         in_sp_ff <= req_ch.setpoint;
         in_ms_ff <= req_ch.measured;
      end
   end

   // Result register valid: drop on a taken beat unless refilled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (move) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (move) begin
         rsp_drive_ff <= rsp_drive_in;
         rsp_frz_ff   <= rsp_frz_in;
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.drive        = rsp_drive_ff;
   assign rsp_ch.integ_frozen = rsp_frz_ff;

endmodule

// ----- src/pidaw_regs.sv -----
// APB-style configuration register file for the PID controller.
// Uses the register map in pidaw_pkg.
module pidaw_regs #(
   parameter int DW     = 32,
   parameter int CSR_DW = 32,
   parameter int CSR_AW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]    prdata,
   output logic signed [DW-1:0] coef [pidaw_pkg::NUM_REGS]
);

   localparam int STRIDE_LOG = CSR_AW - $clog2(pidaw_pkg::NUM_REGS);
   localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

   logic signed [DW-1:0]          regs_ff [pidaw_pkg::NUM_REGS];
   pidaw_pkg::csr_index_type      idx;
   logic                          wr_en;

   assign idx   = pidaw_pkg::csr_index_type'(paddr[CSR_AW-1:STRIDE_LOG]);
   assign wr_en = psel && penable && pwrite;

   // Write on the access phase; limits reset wide open
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[pidaw_pkg::REG_PROP_GAIN]   <= '0;
         regs_ff[pidaw_pkg::REG_INTEG_COEF]  <= '0;
         regs_ff[pidaw_pkg::REG_DERIV_NUM]   <= '0;
         regs_ff[pidaw_pkg::REG_DERIV_DEN]   <= '0;
         regs_ff[pidaw_pkg::REG_INTEG_UPPER] <= DMAX;
         regs_ff[pidaw_pkg::REG_INTEG_LOWER] <= DMIN;
         regs_ff[pidaw_pkg::REG_OUT_UPPER]   <= DMAX;
         regs_ff[pidaw_pkg::REG_OUT_LOWER]   <= DMIN;
      end else if (wr_en) begin
         regs_ff[idx] <= pwdata[DW-1:0];
      end
   end

   // Read back sign-extended to the bus width
   always_comb begin
      logic signed [CSR_DW-1:0] rd;
      rd     = CSR_DW'(regs_ff[idx]);
      prdata = rd;
   end

   assign coef = regs_ff;

endmodule

// ----- src/pidaw_core.sv -----
// PID datapath and loop state: error, clamped trapezoid integral with freeze,
// filtered derivative and clamped output. Uses the register map in pidaw_pkg.
module pidaw_core #(
   parameter int DW   = 32,
   parameter int FRAC = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic signed [DW-1:0] setpoint,
   input  logic signed [DW-1:0] measured,
   input  logic signed [DW-1:0] coef [pidaw_pkg::NUM_REGS],
   output logic signed [DW-1:0] drive,
   output logic                 frozen
);

   localparam int PW = 2 * DW;
   localparam int SW = PW - FRAC;
   localparam int SX = (SW > DW) ? SW : DW;
   localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

   // Saturate a value one bit wider than the data path
   function automatic logic signed [DW-1:0] sat1(input logic signed [DW:0] v);
      logic signed [DW-1:0] r;
      if (v[DW] != v[DW-1]) begin
         r = v[DW] ? DMIN : DMAX;
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   // Full product, floor shift by FRAC, saturate
   function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
      logic signed [PW-1:0] ax;
      logic signed [PW-1:0] bx;
      logic signed [PW-1:0] p;
      logic signed [SX-1:0] s;
      logic signed [DW-1:0] r;
      ax = PW'(a);
      bx = PW'(b);
      p  = ax * bx;
      s  = SX'(p >>> FRAC);
      if ((&s[SX-1:DW-1]) || !(|s[SX-1:DW-1])) begin
         r = s[DW-1:0];
      end else begin
         r = s[SX-1] ? DMIN : DMAX;
      end
      return r;
   endfunction

   logic signed [DW-1:0] last_error_ff, last_error_in;
   logic signed [DW-1:0] integ_acc_ff, integ_acc_in;
   logic signed [DW-1:0] deriv_acc_ff, deriv_acc_in;
   logic                 freeze_ff, freeze_in;

   logic signed [DW:0]   diff;
   logic signed [DW-1:0] err;
   logic signed [DW-1:0] esum;
   logic signed [DW:0]   isum;
   logic signed [DW:0]   dsum;
   logic signed [DW+1:0] ysum;
   logic signed [DW-1:0] kp, ki, kdn, kdd, iup, ilo, oup, olo;

   assign kp  = coef[pidaw_pkg::REG_PROP_GAIN];
   assign ki  = coef[pidaw_pkg::REG_INTEG_COEF];
   assign kdn = coef[pidaw_pkg::REG_DERIV_NUM];
   assign kdd = coef[pidaw_pkg::REG_DERIV_DEN];
   assign iup = coef[pidaw_pkg::REG_INTEG_UPPER];
   assign ilo = coef[pidaw_pkg::REG_INTEG_LOWER];
   assign oup = coef[pidaw_pkg::REG_OUT_UPPER];
   assign olo = coef[pidaw_pkg::REG_OUT_LOWER];

   always_comb begin
      logic signed [DW:0]   spx, msx, ex, lx, ax, px, dnx, ddx;
      logic signed [DW+1:0] p2, i2, d2;
      logic                 opposite, in_band;

      // Error and error sum, saturated
      spx  = (DW+1)'(setpoint);
      msx  = (DW+1)'(measured);
      diff = spx - msx;
      err  = sat1(diff);
      ex   = (DW+1)'(err);
      lx   = (DW+1)'(last_error_ff);
      esum = sat1(ex + lx);

      // Integral: clear when ki is zero, else run, clamp and freeze, or thaw
      ax           = (DW+1)'(integ_acc_ff);
      px           = (DW+1)'(mulq(ki, esum));
      isum         = ax + px;
      integ_acc_in = integ_acc_ff;
      freeze_in    = freeze_ff;
      opposite     = (err < 0 && integ_acc_ff > 0) || (err > 0 && integ_acc_ff < 0);
      in_band      = (integ_acc_ff < iup) && (integ_acc_ff > ilo);
      if (ki == '0) begin
         integ_acc_in = '0;
      end else if (freeze_ff) begin
         if (opposite || in_band) begin
            freeze_in = 1'b0;
         end
      end else if (isum > iup) begin
         integ_acc_in = iup;
         freeze_in    = 1'b1;
      end else if (isum < ilo) begin
         integ_acc_in = ilo;
         freeze_in    = 1'b1;
      end else begin
         integ_acc_in = isum[DW-1:0];
      end

      // Filtered derivative
      dnx  = (DW+1)'(mulq(kdn, esum));
      ddx  = (DW+1)'(mulq(kdd, deriv_acc_ff));
      dsum = dnx - ddx;
      if (kdn == '0) begin
         deriv_acc_in = '0;
      end else begin
         deriv_acc_in = sat1(dsum);
      end

      // Sum and clamp the output
      p2   = (DW+2)'(mulq(err, kp));
      i2   = (DW+2)'(integ_acc_in);
      d2   = (DW+2)'(deriv_acc_in);
      ysum = p2 + i2 + d2;
      if (ysum > oup) begin
         drive = oup;
      end else if (ysum < olo) begin
         drive = olo;
      end else begin
         drive = ysum[DW-1:0];
      end

      last_error_in = err;
      frozen        = freeze_in;
   end

   // Advance loop state once per sample
   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         integ_acc_ff  <= '0;
         deriv_acc_ff  <= '0;
         freeze_ff     <= 1'b0;
      end else if (step) begin
         last_error_ff <= last_error_in;
         integ_acc_ff  <= integ_acc_in;
         deriv_acc_ff  <= deriv_acc_in;
         freeze_ff     <= freeze_in;
      end
   end

endmodule

// ----- src/pidaw_checker.sv -----
// Port-level checker for the PID controller, bound to the top level.
// Depends only on the top level's ports.
module pidaw_checker #(
   parameter int DW = 32
) (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [DW-1:0] rsp_drive,
   input logic          rsp_frozen
);

   logic req_beat;

   assign req_beat = req_valid && req_ready;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_drive) && $stable(rsp_frozen))
      else $error("result payload changed while stalled");

   // Empty result side after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Back-pressure only when both registers are full and the sink stalls
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // No result out of an empty pipeline
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !req_beat) ##1 (!rsp_valid && !req_beat) |=> !rsp_valid)
      else $error("result appeared without a sample");

endmodule

bind pid_antiwindup_filtered_d pidaw_checker #(
   .DW (DATA_WIDTH)
) u_pidaw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_drive  (rsp_ch.drive),
   .rsp_frozen (rsp_ch.integ_frozen)
);
